// ===== design/tmof_pkg.sv =====
// Shared widths, defaults and control types for the temporal median filter.
package tmof_pkg;

  localparam int SAMPLE_W        = 8;
  localparam int CNT_W           = 4;
  localparam int FRAME_COUNT_DEF = 9;
  localparam int CHANNELS        = 3;
  localparam int TDATA_W         = CHANNELS * SAMPLE_W;

  // Insert strobe and current fill count, sent from the top level to each row.
  typedef struct packed {
    logic             insert;
    logic [CNT_W-1:0] held;
  } tmof_ctrl_t;

endpackage

// ===== design/tmof_cell.sv =====
// One insertion-sort cell: holds one sorted sample and hands it to the next cell.
module tmof_cell (
  input  logic                          clk,
  input  logic                          insert,
  input  logic                          occupied,
  input  logic                          at_end,
  input  logic [tmof_pkg::SAMPLE_W-1:0] sample,
  input  logic [tmof_pkg::SAMPLE_W-1:0] prev_val,
  input  logic                          prev_gt,
  output logic [tmof_pkg::SAMPLE_W-1:0] val,
  output logic                          gt,
  output logic [tmof_pkg::SAMPLE_W-1:0] val_nxt
);
  import tmof_pkg::*;

  logic [SAMPLE_W-1:0] val_r;

  // Held entry is larger than the new sample: it moves up one place.
  assign gt = occupied && (val_r > sample);

  always_comb begin
    if (prev_gt) begin
      val_nxt = prev_val;
    end else if (gt || at_end) begin
      val_nxt = sample;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// ===== design/tmof_row.sv =====
// Row of sort cells for one color channel; exposes the middle entry after insert.
module tmof_row #(
  parameter int FRAME_COUNT = tmof_pkg::FRAME_COUNT_DEF
) (
  input  logic                          clk,
  input  tmof_pkg::tmof_ctrl_t          ctrl,
  input  logic [tmof_pkg::SAMPLE_W-1:0] sample,
  output logic [tmof_pkg::SAMPLE_W-1:0] median
);
  import tmof_pkg::*;

  localparam int MED_POS = (FRAME_COUNT - 1) / 2;

  logic [SAMPLE_W-1:0] val     [FRAME_COUNT];
  logic [SAMPLE_W-1:0] val_nxt [FRAME_COUNT];
  logic                gt      [FRAME_COUNT];

  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    logic [SAMPLE_W-1:0] prev_val;
    logic                prev_gt;

    if (i == 0) begin : g_first
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_rest
      assign prev_val = val[i-1];
      assign prev_gt  = gt[i-1];
    end

    tmof_cell u_cell (
      .clk      (clk),
      .insert   (ctrl.insert),
      .occupied (ctrl.held > CNT_W'(i)),
      .at_end   (ctrl.held == CNT_W'(i)),
      .sample   (sample),
      .prev_val (prev_val),
      .prev_gt  (prev_gt),
      .val      (val[i]),
      .gt       (gt[i]),
      .val_nxt  (val_nxt[i])
    );
  end

  // Median of the stack once the new sample is in place.
  assign median = val_nxt[MED_POS];

endmodule

// ===== design/temporal_median_of_nine_rgb_unit.sv =====
// Top level of the temporal median filter over a stack of RGB frames.
//
// Usage:
//   Input channel (in_*): one request per pixel sample, red/green/blue of the
//   same pixel position taken from successive frames. Every FRAME_COUNT
//   requests form one stack.
//   Result channel (out_*): one request per stack, carrying the per-channel
//   median (the entry at (FRAME_COUNT-1)/2 of the sorted stack, i.e. the
//   fifth smallest for nine frames).
//   Throughput: one input request per cycle while in_tready is high. Each
//   channel keeps a row of FRAME_COUNT insertion cells that all shift in
//   the same cycle, so a new sample is sorted into place as it is accepted.
//   Result valid: out_tvalid is registered and rises in the cycle after the
//   last sample of a stack is accepted.
//   Reset: the fill count and the output valid clear; stored samples are
//   left as they are and are overwritten by the next stack.
//   Stall: the result sits in an output register. Samples of the next stack
//   keep flowing while it waits; in_tready drops only while the next sample would
//   close a stack and the previous result is still not taken.
module temporal_median_of_nine_rgb_unit #(
  parameter int FRAME_COUNT = tmof_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [tmof_pkg::TDATA_W-1:0] in_tdata,   // in_red, in_green, in_blue
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [tmof_pkg::TDATA_W-1:0] out_tdata   // med_red, med_green, med_blue
);
  import tmof_pkg::*;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_COUNT - 1);

  logic [CNT_W-1:0]   held_r;
  logic [CNT_W-1:0]   held_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [TDATA_W-1:0] out_data_r;
  logic [TDATA_W-1:0] med_data;
  logic               accept;
  logic               closes_stack;
  tmof_ctrl_t         ctrl;

  // Closing sample of a stack produces a result; hold it off only while the
  // output register is still occupied and stalled.
  assign closes_stack = (held_r == LAST_CNT);
  assign in_tready    = !(closes_stack && out_valid_r && !out_tready);
  assign accept       = in_tvalid && in_tready;

  assign ctrl.insert = accept;
  assign ctrl.held   = held_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    tmof_row #(
      .FRAME_COUNT (FRAME_COUNT)
    ) u_row (
      .clk    (clk),
      .ctrl   (ctrl),
      .sample (in_tdata[c*SAMPLE_W +: SAMPLE_W]),
      .median (med_data[c*SAMPLE_W +: SAMPLE_W])
    );
  end

  // Advance the fill count; wrap to empty after the closing sample.
  always_comb begin
    held_nxt = held_r;
    if (accept) begin
      held_nxt = closes_stack ? '0 : held_r + CNT_W'(1);
    end
  end

  // Load a result on the closing sample, drop it once the receiver takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept && closes_stack) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && closes_stack) begin
      out_data_r <= med_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/tmof_checker.sv =====
// Port-level checks for the temporal median filter, bound to the top level.
module tmof_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [tmof_pkg::TDATA_W-1:0] out_tdata
);
  import tmof_pkg::*;

  // Stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Input backpressure only comes from a stalled pending result.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a pending result");

  // A new result follows an accepted sample.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result without an accepted sample");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind temporal_median_of_nine_rgb_unit tmof_checker u_tmof_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== bench/tmof_median_checker.sv =====
// Checker for the temporal median filter: predicts each stack median and compares.
`timescale 1ns / 100ps

module tmof_median_checker #(
  parameter int FRAME_COUNT = tmof_pkg::FRAME_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [tmof_pkg::TDATA_W-1:0] in_tdata,   // in_red, in_green, in_blue
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [tmof_pkg::TDATA_W-1:0] out_tdata,  // med_red, med_green, med_blue
  output int                           mismatches,
  output int                           medians_owed
);
  import tmof_pkg::*;

  localparam int MID = (FRAME_COUNT - 1) / 2;

  // Red sits in the low byte.
  typedef struct packed {
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] red;
  } rgb_t;

  logic [SAMPLE_W-1:0] sorted_red   [FRAME_COUNT];
  logic [SAMPLE_W-1:0] sorted_green [FRAME_COUNT];
  logic [SAMPLE_W-1:0] sorted_blue  [FRAME_COUNT];
  int                  fill;
  rgb_t                median_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Sorted insertion of one sample; equal values keep arrival order.
  task automatic insert_sample(ref logic [SAMPLE_W-1:0] row [FRAME_COUNT],
                               input logic [SAMPLE_W-1:0] v);
    int pos;
    pos = fill;
    while (pos > 0 && row[pos-1] > v) begin
      row[pos] = row[pos-1];
      pos--;
    end
    row[pos] = v;
  endtask

  task automatic take_pixel(input rgb_t px);
    rgb_t med;
    insert_sample(sorted_red, px.red);
    insert_sample(sorted_green, px.green);
    insert_sample(sorted_blue, px.blue);
    fill++;
    if (fill == FRAME_COUNT) begin
      med.red   = sorted_red[MID];
      med.green = sorted_green[MID];
      med.blue  = sorted_blue[MID];
      median_q.push_back(med);
      fill = 0;
    end
  endtask

  task automatic check_median(input rgb_t got);
    rgb_t want;
    if (median_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result %h", got));
      return;
    end
    want = median_q.pop_front();
    if (got.red !== want.red)
      report_mismatch($sformatf("med_red %h, expected %h", got.red, want.red));
    if (got.green !== want.green)
      report_mismatch($sformatf("med_green %h, expected %h", got.green, want.green));
    if (got.blue !== want.blue)
      report_mismatch($sformatf("med_blue %h, expected %h", got.blue, want.blue));
  endtask

  initial begin
    mismatches   = 0;
    medians_owed = 0;
    fill         = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      fill = 0;
      median_q.delete();
    end else begin
      if (out_tvalid && out_tready) check_median(out_tdata);
      if (in_tvalid && in_tready) take_pixel(in_tdata);
    end
    medians_owed = median_q.size();
  end

endmodule

// ===== bench/tb_temporal_median_of_nine_rgb_unit.sv =====
// Testbench top for the temporal median filter: stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module tb_temporal_median_of_nine_rgb_unit;
  import tmof_pkg::*;

  localparam int FRAMES       = FRAME_COUNT_DEF;
  localparam int RAND_STACKS  = 88;       // 88 x 9 = 792 random pixels
  localparam int QUIET_FIRST  = 30;       // first of the stacks driven without any idling
  localparam int QUIET_LAST   = 45;
  localparam int IDLE_PCT     = 13;
  localparam int STALL_LIMIT  = 2000;     // cycles without any request moving
  localparam int DRAIN_CYCLES = 8;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;    // in_red, in_green, in_blue
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;   // med_red, med_green, med_blue

  int   mismatches;
  int   medians_owed;
  int   quiet_cycles;
  logic quiet;

  temporal_median_of_nine_rgb_unit #(.FRAME_COUNT(FRAMES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tmof_median_checker #(.FRAME_COUNT(FRAMES)) i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .medians_owed (medians_owed)
  );

  // 4 ns period.
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drop out_tready at random with an IDLE_PCT percent chance, except in the quiet stretch.
  always @(negedge clk) begin
    if (rst_n)
      out_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Watchdog: end the run if no request moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL temporal_median_of_nine_rgb_unit");
      $finish;
    end
  end

  // Present one pixel request; idle first at random, then hold until accepted.
  // Leaves in_tvalid high so back-to-back pixels need no extra assignment.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
  endtask

  // One random stack; the flavor decides how often samples repeat.
  task automatic send_random_stack();
    int          flavor;
    logic [7:0]  base;
    logic [7:0]  smp [3];
    flavor = int'($urandom_range(0, 3));
    base   = 8'($urandom_range(0, 255));
    for (int k = 0; k < FRAMES; k++) begin
      for (int c = 0; c < 3; c++) begin
        case (flavor)
          0: smp[c] = 8'($urandom_range(0, 255));                // anything goes
          1: smp[c] = base + 8'($urandom_range(0, 3));           // heavy duplicates
          2: smp[c] = $urandom_range(0, 1) ? 8'hFF : 8'h00;      // extremes only
          default: smp[c] = base ^ (8'h01 << $urandom_range(0, 7)); // one-bit spread
        endcase
      end
      send_pixel(smp[0], smp[1], smp[2]);
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    quiet        = 1'b0;
    quiet_cycles = 0;

    // Hold reset, then release it at a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed stack: red descending with both extremes, green ascending,
    // blue all equal.
    send_pixel(8'hFF, 8'h00, 8'hA5);
    send_pixel(8'hC8, 8'h01, 8'hA5);
    send_pixel(8'hA0, 8'h02, 8'hA5);
    send_pixel(8'h80, 8'h04, 8'hA5);
    send_pixel(8'h7F, 8'h08, 8'hA5);
    send_pixel(8'h40, 8'h10, 8'hA5);
    send_pixel(8'h20, 8'h40, 8'hA5);
    send_pixel(8'h01, 8'h80, 8'hA5);
    send_pixel(8'h00, 8'hFF, 8'hA5);

    // Directed stack: equal samples around the middle, alternating bit patterns.
    send_pixel(8'h00, 8'hFF, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h55);
    send_pixel(8'hFF, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h55);

    // Random stacks, with a stretch where neither side idles.
    for (int s = 0; s < RAND_STACKS; s++) begin
      quiet = (s >= QUIET_FIRST && s <= QUIET_LAST);
      send_random_stack();
    end
    quiet = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain: wait for every owed median, then let the pipeline settle.
    while (medians_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS temporal_median_of_nine_rgb_unit");
    else
      $display("FAIL temporal_median_of_nine_rgb_unit");
    $finish;
  end

endmodule

// ===== temporal_median_of_nine_rgb_unit.f =====
design/tmof_pkg.sv
design/tmof_cell.sv
design/tmof_row.sv
design/temporal_median_of_nine_rgb_unit.sv
design/tmof_checker.sv
bench/tmof_median_checker.sv
bench/tb_temporal_median_of_nine_rgb_unit.sv
